// ===== rtl/pwt_pkg.sv =====
// Shared types and constants for the page walker with TLB.
package pwt_pkg;

  localparam int unsigned VpnBits  = 9;
  localparam int unsigned TagBits  = 45;
  localparam int unsigned PpnBits  = 44;
  localparam int unsigned TlbSets  = 64;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [7:0] FlV = 8'h01;
  localparam logic [7:0] FlR = 8'h02;
  localparam logic [7:0] FlW = 8'h04;
  localparam logic [7:0] FlX = 8'h08;
  localparam logic [7:0] FlU = 8'h10;
  localparam logic [7:0] FlA = 8'h40;
  localparam logic [7:0] FlD = 8'h80;

  typedef enum logic [1:0] {
    MODE_REQ   = 2'd0,
    MODE_RESP  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } in_mode_e;

  typedef enum logic [1:0] {
    RES_READ  = 2'd0,
    RES_WB    = 2'd1,
    RES_DONE  = 2'd2,
    RES_FAULT = 2'd3
  } res_kind_e;

  typedef enum logic [1:0] {
    FC_NONE   = 2'd0,
    FC_PAGE   = 2'd1,
    FC_ACCESS = 2'd2
  } fault_e;

  localparam logic [CfgIdxW-1:0] CfgMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRoot = 1'b1;

  // One queued result beat, already classified by the front part.
  typedef struct packed {
    res_kind_e  kind;
    logic [63:0] addr;
    logic [7:0]  flags;
    fault_e      code;
    logic        last;
  } res_t;

  function automatic logic user_ok(logic [7:0] f, logic [1:0] priv, logic sum);
    if ((f & FlU) != 8'h00) return (priv == 2'd0) || sum;
    return priv != 2'd0;
  endfunction

  function automatic logic perm_ok(logic [7:0] f, logic [1:0] kind);
    logic [3:0] need;
    need = (kind == 2'd0) ? 4'h0 : (4'h1 << kind);
    return (f[3:0] & need) == need;
  endfunction

endpackage

// ===== rtl/pwt_queue.sv =====
// Two-entry result queue between the translation core and the output port.
module pwt_queue
  import pwt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  input  logic push2_i,
  input  res_t push2_data_i,
  output logic empty_o,
  output logic pop_valid_o,
  output res_t pop_data_o
);

  res_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q;
  logic       wr_q;

  assign empty_o     = (cnt_q == 2'd0);
  assign pop_valid_o = !empty_o;
  assign pop_data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (pop_valid_o) cnt_d = cnt_d - 2'd1;
    if (push_i) cnt_d = cnt_d + 2'd1;
    if (push2_i) cnt_d = cnt_d + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (pop_valid_o) rd_q <= ~rd_q;
      if (push_i && push2_i) wr_q <= wr_q;
      else if (push_i) wr_q <= ~wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
    if (push_i && push2_i) mem_q[~wr_q] <= push2_data_i;
  end

endmodule

// ===== rtl/pwt_core.sv =====
// Translation core: request classification, TLB, and walk state.
module pwt_core
  import pwt_pkg::*;
#(
  parameter int unsigned PhysAddrBits = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [1:0]  mode_i,
  input  logic [63:0] virt_addr_i,
  input  logic [1:0]  access_kind_i,
  input  logic [1:0]  privilege_i,
  input  logic        supervisor_user_access_i,
  input  logic [63:0] entry_value_i,
  input  logic        entry_read_ok_i,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        hold_o,
  output logic        push_o,
  output res_t        push_data_o,
  output logic        push2_o,
  output res_t        push2_data_o
);

  localparam int unsigned SetW = (TlbSets > 1) ? $clog2(TlbSets) : 1;
  localparam logic [63:0] PaMask =
    (PhysAddrBits >= 64) ? '1 : ((64'd1 << PhysAddrBits) - 64'd1);

  logic [1:0]         tmode_q;
  logic [PpnBits-1:0] root_q;
  logic               busy_q;
  logic [2:0]         lvl_q;
  logic [PhysAddrBits-1:0] wea_q;
  logic [63:0]        pva_q;
  logic [1:0]         pkind_q, ppriv_q;
  logic               psum_q;

  logic [TlbSets-1:0] tv_q;
  logic [TagBits-1:0] ttag_q [TlbSets];
  logic [PpnBits-1:0] tppn_q [TlbSets];
  logic [PhysAddrBits-1:0] tea_q [TlbSets];
  logic [7:0]         tfl_q  [TlbSets];

  // Item held for classification, with the TLB read data taken alongside
  logic               item_vld_q;
  logic [1:0]         item_mode_q;
  logic [63:0]        item_va_q;
  logic [1:0]         item_kind_q;
  logic [1:0]         item_priv_q;
  logic               item_sum_q;
  logic [63:0]        item_pte_q;
  logic               item_ok_q;
  logic [TagBits-1:0] rd_tag_q;
  logic [PpnBits-1:0] rd_ppn_q;
  logic [7:0]         rd_fl_q;
  logic [PhysAddrBits-1:0] wb_ea_q;
  logic [7:0]         wb_fl_q;

  // Set index from VPN low bits
  function automatic logic [SetW-1:0] set_of(logic [63:0] va);
    logic [63:0] v;
    v = va >> 12;
    return (TlbSets > 1) ? v[SetW-1:0] : '0;
  endfunction

  function automatic logic [8:0] vpn_at(logic [63:0] va, logic [2:0] l);
    logic [63:0] s;
    s = va >> (12 + 9 * l);
    return s[8:0];
  endfunction

  logic [SetW-1:0] rs, ws, rd_set;
  logic [2:0]  levels, top_lvl;
  logic [6:0]  top;
  logic [63:0] upper, ones;
  logic        hit;
  logic [7:0]  hf;
  logic [7:0]  f;
  logic [PpnBits-1:0] ppn;
  logic [63:0] mask, pa, ea;
  logic [63:0] lowmask;

  res_t r1, r2;
  logic p1, p2;
  logic start_walk, step_walk, end_walk, fill, upd_hit;
  logic [2:0] nlvl;
  logic [PhysAddrBits-1:0] nea;
  logic [7:0] hf_new;

  assign hold_o = item_vld_q;

  always_comb begin
    rd_set = set_of(virt_addr_i);
    rs = set_of(item_va_q);
    ws = set_of(pva_q);
    levels = {1'b0, tmode_q} + 3'd2;
    top_lvl = levels - 3'd1;
    top = 7'(12 + 9 * levels - 1);
    upper = item_va_q >> top;
    ones = 64'hFFFF_FFFF_FFFF_FFFF >> top;
    hit = tv_q[rs] && (rd_tag_q == item_va_q[56:12]);
    hf = rd_fl_q;
    hf_new = hf | FlA | ((item_kind_q == 2'd2) ? FlD : 8'h00);
    f = item_pte_q[7:0];
    ppn = item_pte_q[53:10];
    lowmask = (64'd1 << (9 * lvl_q)) - 64'd1;
    mask = (64'd1 << (12 + 9 * lvl_q)) - 64'd1;
    pa = ((({20'd0, ppn} << 12) & ~mask) | (pva_q & mask)) & PaMask;
    r1 = '{kind: RES_DONE, addr: '0, flags: '0, code: FC_NONE, last: 1'b1};
    r2 = r1;
    p1 = 1'b0; p2 = 1'b0;
    start_walk = 1'b0; step_walk = 1'b0; end_walk = 1'b0; fill = 1'b0;
    upd_hit = 1'b0;
    nlvl = lvl_q - 3'd1;
    nea = '0;
    ea = '0;
    if (item_vld_q) begin
      case (in_mode_e'(item_mode_q))
        MODE_REQ: begin
          if (item_priv_q == 2'd3 || tmode_q == 2'd0) begin
            p1 = 1'b1; r1.addr = item_va_q;
          end else if (!busy_q) begin
            p1 = 1'b1;
            if (upper != 64'd0 && upper != ones) begin
              r1.kind = RES_FAULT; r1.code = FC_PAGE; r1.addr = item_va_q;
            end else if (hit) begin
              if (!perm_ok(hf, item_kind_q) ||
                  !user_ok(hf, item_priv_q, item_sum_q)) begin
                r1.kind = RES_FAULT; r1.code = FC_PAGE; r1.addr = item_va_q;
              end else begin
                upd_hit = 1'b1;
                r1.addr = (({20'd0, rd_ppn_q} << 12) |
                           {52'd0, item_va_q[11:0]}) & PaMask;
              end
            end else begin
              start_walk = 1'b1;
              ea = (({20'd0, root_q} << 12) +
                    {52'd0, vpn_at(item_va_q, top_lvl), 3'd0}) & PaMask;
              nea = ea[PhysAddrBits-1:0];
              r1.kind = RES_READ; r1.addr = ea;
            end
          end
        end
        MODE_RESP: begin
          if (busy_q) begin
            p1 = 1'b1;
            r1.kind = RES_FAULT; r1.addr = pva_q; r1.code = FC_PAGE;
            end_walk = 1'b1;
            if (!item_ok_q) begin
              r1.code = FC_ACCESS;
            end else if ((f & FlV) == 8'h00 ||
                         ((f & FlW) != 8'h00 && (f & FlR) == 8'h00)) begin
              r1.code = FC_PAGE;
            end else if ((f & (FlR | FlX)) == 8'h00) begin
              if (lvl_q != 3'd0) begin
                end_walk = 1'b0; step_walk = 1'b1;
                ea = (({20'd0, ppn} << 12) +
                      {52'd0, vpn_at(pva_q, nlvl), 3'd0}) & PaMask;
                nea = ea[PhysAddrBits-1:0];
                r1.kind = RES_READ; r1.addr = ea; r1.code = FC_NONE;
              end
            end else if (({20'd0, ppn} & lowmask) != 64'd0 ||
                         !user_ok(f, ppriv_q, psum_q) ||
                         !perm_ok(f, pkind_q)) begin
              r1.code = FC_PAGE;
            end else begin
              fill = 1'b1;
              r1.code = FC_NONE;
              if (tv_q[ws]) begin
                r1.kind = RES_WB; r1.addr = 64'(wb_ea_q);
                r1.flags = wb_fl_q; r1.last = 1'b0;
                p2 = 1'b1;
                r2.addr = pa;
              end else begin
                r1.kind = RES_DONE; r1.addr = pa;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push_o = p1;
  assign push_data_o = r1;
  assign push2_o = p2;
  assign push2_data_o = r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q  <= 1'b0;
      item_mode_q <= 2'd0;
      item_va_q   <= '0;
      item_kind_q <= 2'd0;
      item_priv_q <= 2'd0;
      item_sum_q  <= 1'b0;
      item_pte_q  <= '0;
      item_ok_q   <= 1'b0;
    end else begin
      item_vld_q <= go_i;
      if (go_i) begin
        item_mode_q <= mode_i;
        item_va_q   <= virt_addr_i;
        item_kind_q <= access_kind_i;
        item_priv_q <= privilege_i;
        item_sum_q  <= supervisor_user_access_i;
        item_pte_q  <= entry_value_i;
        item_ok_q   <= entry_read_ok_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmode_q <= 2'd0;
      root_q  <= '0;
      busy_q  <= 1'b0;
      lvl_q   <= 3'd0;
      wea_q   <= '0;
      pva_q   <= '0;
      pkind_q <= 2'd0;
      ppriv_q <= 2'd0;
      psum_q  <= 1'b0;
      tv_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgMode) tmode_q <= cfg_data_i[1:0];
      else root_q <= cfg_data_i[PpnBits-1:0];
      tv_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      if (item_vld_q && in_mode_e'(item_mode_q) == MODE_FLUSH) tv_q <= '0;
      if (start_walk) begin
        busy_q  <= 1'b1;
        lvl_q   <= top_lvl;
        wea_q   <= nea;
        pva_q   <= item_va_q;
        pkind_q <= item_kind_q;
        ppriv_q <= item_priv_q;
        psum_q  <= item_sum_q;
      end
      if (step_walk) begin
        lvl_q <= nlvl;
        wea_q <= nea;
      end
      if (end_walk) busy_q <= 1'b0;
      if (fill) tv_q[ws] <= 1'b1;
    end
  end

  // TLB arrays: read at the accept edge, written when the item is classified
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rd_tag_q <= ttag_q[rd_set];
      rd_ppn_q <= tppn_q[rd_set];
      rd_fl_q  <= tfl_q[rd_set];
      wb_ea_q  <= tea_q[ws];
      wb_fl_q  <= tfl_q[ws];
    end
    if (upd_hit && !cfg_we_i) tfl_q[rs] <= hf_new;
    if (fill && !cfg_we_i) begin
      ttag_q[ws] <= pva_q[56:12];
      tppn_q[ws] <= pa[55:12];
      tea_q[ws]  <= wea_q;
      tfl_q[ws]  <= f;
    end
  end

endmodule

// ===== rtl/riscv_page_walker_with_tlb.sv =====
// Top level: RISC-V Sv39/48/57 MMU with direct-mapped TLB and walker.
// Usage: pulse start with mode_i and payload while busy is low.
// The front part registers the item together with the TLB read data and
// classifies it in the following cycle: bare/machine pass-through,
// canonical fault, TLB hit or a walk start.
// A walk emits one PTE read request beat per level; each PTE comes back
// as a response item (mode 1). Flush (mode 2) clears the TLB silently.
// Results go into a two-entry queue and leave one beat a cycle on
// result_valid_o; an item yields at most one beat, two when a walk fill evicts
// a valid entry (flag writeback first, then the translation).
// The first result beat is registered in the item register and then in the
// queue before it shows. busy stays high until the queue has drained, so
// the block takes no new item before it is through with the last one.
// Configuration writes flush the TLB and abandon any walk.
// Reset clears TLB valid bits, walk state and the queue; TLB payload is
// left unset. The receiver cannot stall: each beat shows for one cycle.
module riscv_page_walker_with_tlb
  import pwt_pkg::*;
#(
  parameter int unsigned PHYS_ADDR_BITS = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [63:0] virt_addr_i,
  input  logic [1:0]  access_kind_i,
  input  logic [1:0]  privilege_i,
  input  logic        supervisor_user_access_i,
  input  logic [63:0] entry_value_i,
  input  logic        entry_read_ok_i,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [63:0] out_addr_o,
  output logic [7:0]  writeback_flags_o,
  output logic [1:0]  fault_code_o,
  output logic        last_o
);

  logic go, push, push2, empty, pv, hold;
  res_t d1, d2, q;

  assign busy = !empty || hold;
  assign go = start && !busy;

  pwt_core #(.PhysAddrBits(PHYS_ADDR_BITS)) u_core (
    .clk_i, .rst_ni, .go_i(go), .mode_i, .virt_addr_i, .access_kind_i,
    .privilege_i, .supervisor_user_access_i, .entry_value_i, .entry_read_ok_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .hold_o(hold),
    .push_o(push), .push_data_o(d1), .push2_o(push2), .push2_data_o(d2)
  );

  pwt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(d1), .push2_i(push2),
    .push2_data_i(d2), .empty_o(empty), .pop_valid_o(pv), .pop_data_o(q)
  );

  assign result_valid_o    = pv;
  assign result_kind_o     = q.kind;
  assign out_addr_o        = q.addr;
  assign writeback_flags_o = q.flags;
  assign fault_code_o      = q.code;
  assign last_o            = q.last;

endmodule
